FILE: rtl/core/efws_pkg.sv
`timescale 1ns / 1ps

package efws_pkg;

   // sizes of the worker table and the fields
   localparam int MAX_WORKERS = 16;
   localparam int IDX_W       = $clog2(MAX_WORKERS);
   localparam int CNT_W       = 5;
   localparam int TIME_W      = 48;
   localparam int DUR_W       = 32;

   // search tree: groups of four workers, then four group winners
   localparam int GROUP_SIZE  = 4;
   localparam int GROUPS      = MAX_WORKERS / GROUP_SIZE;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // one queued job as seen by the back part
   typedef struct packed {
      logic             valid;
      logic [DUR_W-1:0] duration;
   } job_type;

   // one contender in the earliest-free search
   typedef struct packed {
      logic              ok;
      logic [IDX_W-1:0]  idx;
      logic [TIME_W-1:0] free_at;
   } cand_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_GROUP  = 4'b0010,
      ST_FINAL  = 4'b0100,
      ST_UPDATE = 4'b1000
   } back_state_type;

   // lower-index contender wins ties
   function automatic cand_type pick_earlier(cand_type lo, cand_type hi);
      if (lo.ok && (!hi.ok || lo.free_at <= hi.free_at)) begin
         return lo;
      end
      return hi;
   endfunction

endpackage

FILE: rtl/core/efws_front.sv
`timescale 1ns / 1ps

module efws_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [efws_pkg::DUR_W-1:0] req_job_duration,
   input  logic                       pop,
   output efws_pkg::job_type          job
);

   logic [efws_pkg::DUR_W-1:0]  queue_ff [efws_pkg::QUEUE_DEPTH];
   logic [efws_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [efws_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [efws_pkg::QCNT_W-1:0] count_ff;
   logic [efws_pkg::QCNT_W-1:0] count_in;
   logic                        full;
   logic                        push;
   logic                        do_pop;

   // accept a word whenever the queue has room
   assign full   = (count_ff == efws_pkg::QCNT_W'(efws_pkg::QUEUE_DEPTH));
   assign busy   = full;
   assign push   = start && !full;
   assign do_pop = pop && (count_ff != '0);

   assign job.valid    = (count_ff != '0);
   assign job.duration = queue_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= req_job_duration;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= efws_pkg::QCNT_W'(efws_pkg::QUEUE_DEPTH))
      else $error("job queue over capacity");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("back part popped an empty queue");

endmodule

FILE: rtl/core/efws_back.sv
`timescale 1ns / 1ps

module efws_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [efws_pkg::CNT_W-1:0]  csr_write_data,
   input  efws_pkg::job_type           job,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic [efws_pkg::IDX_W-1:0]  rsp_worker_index,
   output logic [efws_pkg::TIME_W-1:0] rsp_start_time,
   output logic                        rsp_time_saturated
);

   efws_pkg::back_state_type    state_ff;
   efws_pkg::back_state_type    state_in;
   logic [efws_pkg::CNT_W-1:0]  count_ff;
   logic [efws_pkg::CNT_W-1:0]  n_active;
   logic [efws_pkg::TIME_W-1:0] free_time_ff [efws_pkg::MAX_WORKERS];
   logic [efws_pkg::DUR_W-1:0]  dur_ff;
   efws_pkg::cand_type          cand [efws_pkg::MAX_WORKERS];
   efws_pkg::cand_type          group_in [efws_pkg::GROUPS];
   efws_pkg::cand_type          group_ff [efws_pkg::GROUPS];
   efws_pkg::cand_type          best_in;
   efws_pkg::cand_type          best_ff;
   logic [efws_pkg::TIME_W:0]   sum;
   logic                        sat;
   logic                        rsp_valid_ff;
   logic [efws_pkg::IDX_W-1:0]  rsp_worker_index_ff;
   logic [efws_pkg::TIME_W-1:0] rsp_start_time_ff;
   logic                        rsp_time_saturated_ff;

   // active worker count, zero means one, clipped at the table size
   always_comb begin
      if (count_ff == '0) begin
         n_active = efws_pkg::CNT_W'(1);
      end else if (count_ff > efws_pkg::CNT_W'(efws_pkg::MAX_WORKERS)) begin
         n_active = efws_pkg::CNT_W'(efws_pkg::MAX_WORKERS);
      end else begin
         n_active = count_ff;
      end
   end

   // contenders, inactive workers drop out
   always_comb begin
      for (int i = 0; i < efws_pkg::MAX_WORKERS; i++) begin
         cand[i].ok      = (efws_pkg::CNT_W'(i) < n_active);
         cand[i].idx     = efws_pkg::IDX_W'(i);
         cand[i].free_at = free_time_ff[i];
      end
   end

   // first tree half: winner of each group of four
   always_comb begin
      for (int g = 0; g < efws_pkg::GROUPS; g++) begin
         group_in[g] = efws_pkg::pick_earlier(
            efws_pkg::pick_earlier(cand[4*g],   cand[4*g+1]),
            efws_pkg::pick_earlier(cand[4*g+2], cand[4*g+3]));
      end
   end

   // second tree half: winner of the group winners
   assign best_in = efws_pkg::pick_earlier(
      efws_pkg::pick_earlier(group_ff[0], group_ff[1]),
      efws_pkg::pick_earlier(group_ff[2], group_ff[3]));

   // new free time with clipping
   assign sum = {1'b0, best_ff.free_at} + {{(efws_pkg::TIME_W + 1 - efws_pkg::DUR_W){1'b0}}, dur_ff};
   assign sat = sum[efws_pkg::TIME_W];

   // take the next job when idle or while finishing the current one
   assign pop = job.valid && (state_ff == efws_pkg::ST_IDLE || state_ff == efws_pkg::ST_UPDATE);

   // sequencer
   always_comb begin
      case (state_ff)
         efws_pkg::ST_IDLE: begin
            state_in = job.valid ? efws_pkg::ST_GROUP : efws_pkg::ST_IDLE;
         end
         efws_pkg::ST_GROUP: begin
            state_in = efws_pkg::ST_FINAL;
         end
         efws_pkg::ST_FINAL: begin
            state_in = efws_pkg::ST_UPDATE;
         end
         efws_pkg::ST_UPDATE: begin
            state_in = job.valid ? efws_pkg::ST_GROUP : efws_pkg::ST_IDLE;
         end
         default: begin
            state_in = efws_pkg::ST_IDLE;
         end
      endcase
   end

   // control state, worker count and free-time table
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efws_pkg::ST_IDLE;
         count_ff     <= efws_pkg::CNT_W'(efws_pkg::MAX_WORKERS);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < efws_pkg::MAX_WORKERS; i++) begin
            free_time_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == efws_pkg::ST_UPDATE);
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
            for (int i = 0; i < efws_pkg::MAX_WORKERS; i++) begin
               free_time_ff[i] <= '0;
            end
         end else if (state_ff == efws_pkg::ST_UPDATE) begin
            free_time_ff[best_ff.idx] <= sat ? efws_pkg::TIME_MAX
                                             : sum[efws_pkg::TIME_W-1:0];
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         dur_ff <= job.duration;
      end
      if (state_ff == efws_pkg::ST_GROUP) begin
         group_ff <= group_in;
      end
      if (state_ff == efws_pkg::ST_FINAL) begin
         best_ff <= best_in;
      end
      if (state_ff == efws_pkg::ST_UPDATE) begin
         rsp_worker_index_ff   <= best_ff.idx;
         rsp_start_time_ff     <= best_ff.free_at;
         rsp_time_saturated_ff <= sat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_worker_index   = rsp_worker_index_ff;
   assign rsp_start_time     = rsp_start_time_ff;
   assign rsp_time_saturated = rsp_time_saturated_ff;

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == efws_pkg::ST_UPDATE))
      else $error("result strobe without an update step");

   a_best_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == efws_pkg::ST_UPDATE |-> best_ff.ok)
      else $error("search picked no active worker");

   a_sat_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_time_saturated_ff && !$past(csr_write_enable)
      |-> free_time_ff[rsp_worker_index_ff] == efws_pkg::TIME_MAX)
      else $error("clipped free time not stored at maximum");

endmodule

FILE: rtl/core/earliest_free_worker_scheduler_top.sv
`timescale 1ns / 1ps

// Earliest-free-worker job scheduler. Each word taken on start/busy is a job
// duration; the block picks the active worker with the smallest free time
// (lowest index on a tie), returns it with its start time, and moves that
// worker's free time to start plus duration, clipped at 2^48-1 with
// rsp_time_saturated set. Results appear for one cycle on rsp_valid and the
// receiver cannot stall them. A two-word queue takes jobs while the
// scheduler works; busy is high only while that queue is full. The
// scheduler works on one job at a time: a registered min-search tree over
// the sixteen free times finds the group winners, then the overall winner,
// and an update step does the add and table write. The next job is taken
// from the queue during that update step, and the result is registered from
// it. Writing csr_write_data sets the worker count and clears all free
// times; write it only while no job is in flight.
module earliest_free_worker_scheduler_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [efws_pkg::DUR_W-1:0]  req_job_duration,
   output logic                        rsp_valid,
   output logic [efws_pkg::IDX_W-1:0]  rsp_worker_index,
   output logic [efws_pkg::TIME_W-1:0] rsp_start_time,
   output logic                        rsp_time_saturated,
   input  logic                        csr_write_enable,
   input  logic [efws_pkg::CNT_W-1:0]  csr_write_data
);

   efws_pkg::job_type job;
   logic              pop;

   // job intake and queue
   efws_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_job_duration (req_job_duration),
      .pop              (pop),
      .job              (job)
   );

   // search, update and result
   efws_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .job                (job),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_worker_index   (rsp_worker_index),
      .rsp_start_time     (rsp_start_time),
      .rsp_time_saturated (rsp_time_saturated)
   );

endmodule

FILE: bench/earliest_free_worker_scheduler_top_test.sv
`timescale 1ns / 1ps

module earliest_free_worker_scheduler_top_test;

   // one job assignment as the block reports it
   typedef struct packed {
      logic [efws_pkg::IDX_W-1:0]  worker;
      logic [efws_pkg::TIME_W-1:0] start_at;
      logic                        clipped;
   } assignment_type;

   // mirror of the worker free-time table and the queue of assignments due
   class free_time_tracker;
      logic [efws_pkg::TIME_W-1:0] free_at [efws_pkg::MAX_WORKERS];
      int unsigned                 active_workers;
      assignment_type              assignments_due [$];
      int unsigned                 errors;

      function new();
         errors = 0;
         set_worker_count(efws_pkg::CNT_W'(16));
      endfunction

      // zero means one worker, anything past the table size means all of them
      function void set_worker_count(logic [efws_pkg::CNT_W-1:0] value);
         if (value == 0) begin
            active_workers = 1;
         end else if (value > efws_pkg::MAX_WORKERS) begin
            active_workers = efws_pkg::MAX_WORKERS;
         end else begin
            active_workers = value;
         end
         foreach (free_at[i]) free_at[i] = '0;
      endfunction

      // earliest free worker, lowest index on a tie, clip at the time maximum
      function void note_job(logic [efws_pkg::DUR_W-1:0] duration);
         int unsigned               best;
         logic [efws_pkg::TIME_W:0] sum;
         assignment_type            a;
         best = 0;
         for (int unsigned i = 1; i < active_workers; i++) begin
            if (free_at[i] < free_at[best]) best = i;
         end
         sum = {1'b0, free_at[best]}
               + {{(efws_pkg::TIME_W + 1 - efws_pkg::DUR_W){1'b0}}, duration};
         a.worker   = efws_pkg::IDX_W'(best);
         a.start_at = free_at[best];
         a.clipped  = sum[efws_pkg::TIME_W];
         free_at[best] = a.clipped ? efws_pkg::TIME_MAX : sum[efws_pkg::TIME_W-1:0];
         assignments_due.push_back(a);
      endfunction

      function void check_result(logic [efws_pkg::IDX_W-1:0] worker,
                                 logic [efws_pkg::TIME_W-1:0] start_at,
                                 logic clipped);
         assignment_type a;
         if (assignments_due.size() == 0) begin
            $error("unexpected result: worker_index %0d start_time %0h", worker, start_at);
            errors++;
            return;
         end
         a = assignments_due.pop_front();
         if (worker !== a.worker) begin
            $error("worker_index: expected %0d, actual %0d", a.worker, worker);
            errors++;
         end
         if (start_at !== a.start_at) begin
            $error("start_time: expected %0h, actual %0h", a.start_at, start_at);
            errors++;
         end
         if (clipped !== a.clipped) begin
            $error("time_saturated: expected %0b, actual %0b", a.clipped, clipped);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return assignments_due.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [efws_pkg::DUR_W-1:0]  req_job_duration = '0;
   logic                        rsp_valid;
   logic [efws_pkg::IDX_W-1:0]  rsp_worker_index;
   logic [efws_pkg::TIME_W-1:0] rsp_start_time;
   logic                        rsp_time_saturated;
   logic                        csr_write_enable = 1'b0;
   logic [efws_pkg::CNT_W-1:0]  csr_write_data = '0;

   free_time_tracker schedule = new();

   earliest_free_worker_scheduler_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_job_duration   (req_job_duration),
      .rsp_valid          (rsp_valid),
      .rsp_worker_index   (rsp_worker_index),
      .rsp_start_time     (rsp_start_time),
      .rsp_time_saturated (rsp_time_saturated),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // watch accepted words, register writes and results at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) schedule.set_worker_count(csr_write_data);
         if (start && !busy) schedule.note_job(req_job_duration);
         if (rsp_valid) schedule.check_result(rsp_worker_index, rsp_start_time,
                                              rsp_time_saturated);
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap(bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // small durations give ties and reorderings, the rest covers the full range
   function automatic logic [efws_pkg::DUR_W-1:0] pick_duration();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return $urandom;
         4: return $urandom_range(3);
         default: return $urandom_range(500);
      endcase
   endfunction

   task automatic send_job(input logic [efws_pkg::DUR_W-1:0] duration,
                           input int unsigned gap);
      start <= 1'b1;
      req_job_duration <= duration;
      do @(posedge clock); while (busy);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for every due assignment, then let the pipeline settle
   task automatic drain();
      int unsigned waited;
      start <= 1'b0;
      waited = 0;
      while (schedule.pending() != 0 && waited < 400) begin
         @(posedge clock);
         waited++;
      end
      if (schedule.pending() != 0) begin
         $error("%0d results never arrived", schedule.pending());
         schedule.errors++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_worker_count(input logic [efws_pkg::CNT_W-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [efws_pkg::CNT_W-1:0] count_value,
                            input int unsigned jobs);
      bit steady;
      write_worker_count(count_value);
      steady = 1'b0;
      for (int unsigned n = 0; n < jobs; n++) begin
         // switch between idle-free stretches and gappy ones
         if (n % 16 == 0) steady = ($urandom_range(3) == 0);
         send_job(pick_duration(), pick_gap(steady));
      end
   endtask

   initial begin
      logic [efws_pkg::DUR_W-1:0] edge_durations [$];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // field extremes and ties under the reset worker count
      edge_durations = '{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h0, 32'h2, 32'h3,
                         32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
                         32'h10, 32'h0};
      foreach (edge_durations[i]) send_job(edge_durations[i], pick_gap(i < 10));

      // count zero runs one worker; long jobs pile up on it
      write_worker_count(efws_pkg::CNT_W'(0));
      for (int unsigned n = 0; n < 8; n++) send_job('1, 0);
      send_job('1, 0);
      send_job('0, 0);
      send_job(32'h1, 2);
      send_job('1, 5);
      send_job('0, 0);

      // random jobs under a spread of worker counts
      run_phase(efws_pkg::CNT_W'(1), 60);
      run_phase(efws_pkg::CNT_W'(31), 70);
      run_phase(efws_pkg::CNT_W'(2), 60);
      run_phase(efws_pkg::CNT_W'(16), 70);
      run_phase(efws_pkg::CNT_W'(17), 50);
      run_phase(efws_pkg::CNT_W'($urandom_range(15, 3)), 70);
      run_phase(efws_pkg::CNT_W'($urandom_range(31)), 70);

      drain();
      repeat (10) @(posedge clock);
      if (schedule.errors == 0 && schedule.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
